// ----- sv/jtsl_pkg.sv -----
// Shared types and constants for the joint trapezoid step limiter.
// No dependencies; imported by every module of the block.
`default_nettype none

package jtsl_pkg;

    localparam int JOINT_W = 3;
    localparam int POS_W   = 32;
    localparam int STEP_W  = 24;
    localparam int DIST_W  = 28;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // Command codes of the input transaction
    localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROFILE_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_CHANGE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DISTANCE = 2'd3;

    // Reset values of the configuration registers
    localparam logic              RST_PROFILE_MODE  = 1'b1;
    localparam logic [STEP_W-1:0] RST_STEP_LIMIT    = 24'd80531;
    localparam logic [STEP_W-1:0] RST_STEP_CHANGE   = 24'd8053;
    localparam logic [DIST_W-1:0] RST_RAMP_DISTANCE = 28'd402653;

    localparam logic profile_constant = 1'b0;

    typedef struct packed {
        logic              profile_mode;
        logic [STEP_W-1:0] step_limit;
        logic [STEP_W-1:0] step_change;
        logic [DIST_W-1:0] ramp_distance;
    } cfg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] command_position;
        logic [STEP_W-1:0]       ramp_next;
    } calc_res_t;

endpackage

`default_nettype wire

// ----- sv/jtsl_step_calc.sv -----
// Combinational step calculation for one tick: error, step select, saturation.
// Depends on jtsl_pkg.
`default_nettype none

module jtsl_step_calc (
    input  jtsl_pkg::cfg_t                      cfg,
    input  logic signed [jtsl_pkg::POS_W-1:0]   goal,
    input  logic signed [jtsl_pkg::POS_W-1:0]   prev,
    input  logic [jtsl_pkg::STEP_W-1:0]         ramp,
    input  logic signed [jtsl_pkg::POS_W-1:0]   meas,
    output jtsl_pkg::calc_res_t                 res
);
    import jtsl_pkg::*;

    logic signed [POS_W:0]   err;
    logic [POS_W:0]          mag;
    logic                    err_pos;
    logic [STEP_W:0]         inc_sum;
    logic [STEP_W-1:0]       step_inc;
    logic [STEP_W-1:0]       step_dec;
    logic [STEP_W-1:0]       step_sel;
    logic [STEP_W-1:0]       ramp_upd;
    logic                    use_goal;
    logic signed [POS_W+1:0] base_ext;
    logic signed [POS_W+1:0] tsum;
    logic signed [POS_W-1:0] toward_pos;

    assign err     = {goal[POS_W-1], goal} - {meas[POS_W-1], meas};
    assign mag     = err[POS_W] ? ((POS_W+1)'(0) - err) : err;
    assign err_pos = !err[POS_W] && (err != '0);

    assign inc_sum  = {1'b0, ramp} + {1'b0, cfg.step_change};
    assign step_inc = (inc_sum < {1'b0, cfg.step_limit}) ? inc_sum[STEP_W-1:0] : cfg.step_limit;
    assign step_dec = (ramp > cfg.step_change) ? (ramp - cfg.step_change) : '0;

    always_comb begin
        use_goal = 1'b0;
        step_sel = cfg.step_limit;
        ramp_upd = ramp;
        if (cfg.profile_mode == profile_constant) begin
            use_goal = !(mag > {{(POS_W+1-STEP_W){1'b0}}, cfg.step_limit});
        end else if (mag <= {{(POS_W+1-DIST_W){1'b0}}, cfg.ramp_distance}) begin
            // inside the ramp-down zone; a zero step lands on the goal
            if (ramp == '0) begin
                use_goal = 1'b1;
            end else begin
                step_sel = step_dec;
                ramp_upd = step_dec;
            end
        end else begin
            step_sel = step_inc;
            ramp_upd = step_inc;
        end
    end

    assign base_ext = {{2{prev[POS_W-1]}}, prev};
    assign tsum = err_pos ? (base_ext + $signed({{(POS_W+2-STEP_W){1'b0}}, step_sel}))
                          : (base_ext - $signed({{(POS_W+2-STEP_W){1'b0}}, step_sel}));

    // saturate when the top three bits disagree
    always_comb begin
        if (tsum[POS_W+1:POS_W-1] == 3'b000 || tsum[POS_W+1:POS_W-1] == 3'b111) begin
            toward_pos = tsum[POS_W-1:0];
        end else if (tsum[POS_W+1]) begin
            toward_pos = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            toward_pos = {1'b0, {(POS_W-1){1'b1}}};
        end
    end

    assign res = {(use_goal ? goal : toward_pos), ramp_upd};

endmodule

`default_nettype wire

// ----- sv/joint_trapezoid_step_limiter.sv -----
// Path: an accepted input transaction waits in the input register; a tick result then
// goes to the result register, and a stalled result side holds both registers.
// Throughput: one transaction per cycle unless the result side stalls; state is updated
// as an item leaves the input register, so a following item for the same joint sees it.
// Reset: configuration returns to its defaults, every ramp step is cleared,
// both pipeline registers empty; goal and previous angles are not reset.
`default_nettype none

module joint_trapezoid_step_limiter #(
    parameter int JOINT_COUNT = 7
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wen,
    input  wire logic [jtsl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [jtsl_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [jtsl_pkg::CMD_W-1:0]            s_cmd,
    input  wire logic [jtsl_pkg::JOINT_W-1:0]          s_joint_index,
    input  wire logic signed [jtsl_pkg::POS_W-1:0]     s_measured_position,
    input  wire logic signed [jtsl_pkg::POS_W-1:0]     s_target_position,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [jtsl_pkg::JOINT_W-1:0]               m_out_joint,
    output logic signed [jtsl_pkg::POS_W-1:0]          m_command_position
);
    import jtsl_pkg::*;

    localparam int IDX_W = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;

    cfg_t cfg_reg;

    logic signed [POS_W-1:0] goal_reg [JOINT_COUNT];
    logic signed [POS_W-1:0] prev_reg [JOINT_COUNT];
    logic [STEP_W-1:0]       ramp_reg [JOINT_COUNT];

    logic                    v1_reg;
    logic [CMD_W-1:0]        cmd1_reg;
    logic [JOINT_W-1:0]      joint1_reg;
    logic signed [POS_W-1:0] meas1_reg;
    logic signed [POS_W-1:0] tgt1_reg;

    logic                    m_valid_reg;
    logic [JOINT_W-1:0]      m_joint_reg;
    logic signed [POS_W-1:0] m_pos_reg;

    logic                    advance;
    logic                    retire;
    logic                    joint_ok;
    logic [IDX_W-1:0]        idx;
    logic signed [POS_W-1:0] goal_rd;
    logic signed [POS_W-1:0] prev_rd;
    logic [STEP_W-1:0]       ramp_rd;
    calc_res_t               calc;
    logic                    m_valid_next;

    assign advance  = !m_valid_reg || m_ready;
    assign retire   = v1_reg && advance;
    assign s_ready  = !v1_reg || advance;
    assign joint_ok = (32'(joint1_reg) < JOINT_COUNT);
    assign idx      = IDX_W'(joint1_reg);

    always_comb begin
        goal_rd = '0;
        prev_rd = '0;
        ramp_rd = '0;
        if (joint_ok) begin
            goal_rd = goal_reg[idx];
            prev_rd = prev_reg[idx];
            ramp_rd = ramp_reg[idx];
        end
    end

    jtsl_step_calc u_calc (
        .cfg  (cfg_reg),
        .goal (goal_rd),
        .prev (prev_rd),
        .ramp (ramp_rd),
        .meas (meas1_reg),
        .res  (calc)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.profile_mode  <= RST_PROFILE_MODE;
            cfg_reg.step_limit    <= RST_STEP_LIMIT;
            cfg_reg.step_change   <= RST_STEP_CHANGE;
            cfg_reg.ramp_distance <= RST_RAMP_DISTANCE;
        end else if (cfg_wen) begin
            case (cfg_index)
                REG_PROFILE_MODE:  cfg_reg.profile_mode  <= cfg_wdata[0];
                REG_STEP_LIMIT:    cfg_reg.step_limit    <= cfg_wdata[STEP_W-1:0];
                REG_STEP_CHANGE:   cfg_reg.step_change   <= cfg_wdata[STEP_W-1:0];
                REG_RAMP_DISTANCE: cfg_reg.ramp_distance <= cfg_wdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_ready) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            cmd1_reg   <= s_cmd;
            joint1_reg <= s_joint_index;
            meas1_reg  <= s_measured_position;
            tgt1_reg   <= s_target_position;
        end
    end

    // per-joint state, written as the item leaves the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < JOINT_COUNT; j++) begin
                ramp_reg[j] <= '0;
            end
        end else if (retire && joint_ok) begin
            case (cmd1_reg)
                CMD_START, CMD_TARGET: ramp_reg[idx] <= '0;
                CMD_TICK:              ramp_reg[idx] <= calc.ramp_next;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && joint_ok) begin
            case (cmd1_reg)
                CMD_START: begin
                    goal_reg[idx] <= meas1_reg;
                    prev_reg[idx] <= meas1_reg;
                end
                CMD_TARGET: goal_reg[idx] <= tgt1_reg;
                CMD_TICK:   prev_reg[idx] <= meas1_reg;
                default: ;
            endcase
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (retire && joint_ok && cmd1_reg == CMD_TICK) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire && joint_ok && cmd1_reg == CMD_TICK) begin
            m_joint_reg <= joint1_reg;
            m_pos_reg   <= calc.command_position;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_out_joint        = m_joint_reg;
    assign m_command_position = m_pos_reg;

endmodule

`default_nettype wire

// ----- sv/jtsl_checker.sv -----
// Port-level checks for joint_trapezoid_step_limiter, bound to the top level.
// Depends on jtsl_pkg.
`default_nettype none

module jtsl_checker #(
    parameter int JOINT_COUNT = 7
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_ready,
    input  wire logic                               m_valid,
    input  wire logic                               m_ready,
    input  wire logic [jtsl_pkg::JOINT_W-1:0]       m_out_joint,
    input  wire logic signed [jtsl_pkg::POS_W-1:0]  m_command_position
);
    import jtsl_pkg::*;

    // pending result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_joint)
                                && $stable(m_command_position))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input only backs up when the result side is stalled
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    a_joint: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_out_joint) < JOINT_COUNT))
        else $error("result for a joint out of range");

endmodule

bind joint_trapezoid_step_limiter jtsl_checker #(.JOINT_COUNT(JOINT_COUNT)) u_jtsl_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_out_joint        (m_out_joint),
    .m_command_position (m_command_position)
);

`default_nettype wire

// ----- bench/joint_trapezoid_step_limiter_test.sv -----
// Self-checking bench for joint_trapezoid_step_limiter: a directed table, then random
// start/target/tick traffic, all scored against a behavioral position shaper.
// Depends on sv/jtsl_pkg.sv and sv/joint_trapezoid_step_limiter.sv.
`timescale 1ns / 100ps

module joint_trapezoid_step_limiter_test;
    import jtsl_pkg::*;

    localparam int JOINT_COUNT = 7;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam longint POS_MAX = 64'sh7FFF_FFFF;
    localparam longint POS_MIN = -64'sh8000_0000;
    localparam longint STEP_FULL = (64'sd1 << STEP_W) - 1;
    localparam longint DIST_FULL = (64'sd1 << DIST_W) - 1;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [JOINT_W-1:0] joint;
        logic [POS_W-1:0]   meas;
        logic [POS_W-1:0]   tgt;
    } joint_item_t;

    typedef struct packed {
        logic [JOINT_W-1:0] joint;
        logic [POS_W-1:0]   pos;
    } joint_cmd_t;

    typedef struct packed {
        logic                  cfg_row;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        joint_item_t           item;
        logic                  typed;
        logic [POS_W-1:0]      typed_pos;
    } plan_row_t;

    logic                    aclk;
    logic                    aresetn = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_cmd = '0;
    logic [JOINT_W-1:0]      s_joint_index = '0;
    logic signed [POS_W-1:0] s_measured_position = '0;
    logic signed [POS_W-1:0] s_target_position = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [JOINT_W-1:0]      m_out_joint;
    logic signed [POS_W-1:0] m_command_position;

    // shaper state and settings mirrored from the block
    logic              mode_q = RST_PROFILE_MODE;
    logic [STEP_W-1:0] step_limit_q = RST_STEP_LIMIT;
    logic [STEP_W-1:0] step_change_q = RST_STEP_CHANGE;
    logic [DIST_W-1:0] ramp_dist_q = RST_RAMP_DISTANCE;
    longint            goal_q [JOINT_COUNT];
    longint            prev_q [JOINT_COUNT];
    logic [STEP_W-1:0] ramp_q [JOINT_COUNT];

    // stimulus side: which joints hold defined angles, and where each one sits
    bit                started [JOINT_COUNT];
    longint            plant_q [JOINT_COUNT];

    joint_cmd_t cmd_due[$];
    plan_row_t  plan[$];
    int  fault_count = 0;
    int  checked_count = 0;
    int  sent_count = 0;
    int  snd_idle_pct = 15;
    int  rcv_idle_pct = 82;
    int  calm_left = 0;
    bit  calm = 1'b0;

    joint_trapezoid_step_limiter #(.JOINT_COUNT(JOINT_COUNT)) DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wen            (cfg_wen),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_joint_index      (s_joint_index),
        .s_measured_position(s_measured_position),
        .s_target_position  (s_target_position),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_out_joint        (m_out_joint),
        .m_command_position (m_command_position)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic longint sat_pos(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic longint step_toward(input longint base, input longint step,
                                           input longint err);
        return sat_pos(err > 0 ? base + step : base - step);
    endfunction

    // Advances the shaper by one transaction; returns 1 when a command is produced.
    function automatic bit shape_command(input joint_item_t it, output joint_cmd_t res);
        longint err, mag, nxt, step_v, lim_v, dist_v;
        logic [STEP_W:0] grown;
        int unsigned j;
        res = '0;
        j = 32'(it.joint);
        if (j >= JOINT_COUNT) return 0;
        if (it.cmd == CMD_START) begin
            goal_q[j] = longint'($signed(it.meas));
            prev_q[j] = longint'($signed(it.meas));
            ramp_q[j] = '0;
            return 0;
        end
        if (it.cmd == CMD_TARGET) begin
            goal_q[j] = longint'($signed(it.tgt));
            ramp_q[j] = '0;
            return 0;
        end
        if (it.cmd != CMD_TICK) return 0;

        err = goal_q[j] - longint'($signed(it.meas));
        mag = err < 0 ? -err : err;
        lim_v = longint'(step_limit_q);
        dist_v = longint'(ramp_dist_q);
        if (mode_q == profile_constant) begin
            nxt = (mag > lim_v) ? step_toward(prev_q[j], lim_v, err) : goal_q[j];
        end else if (mag <= dist_v) begin
            if (ramp_q[j] == '0) begin
                nxt = goal_q[j];
            end else begin
                ramp_q[j] = (ramp_q[j] > step_change_q) ? ramp_q[j] - step_change_q : '0;
                step_v = longint'(ramp_q[j]);
                nxt = step_toward(prev_q[j], step_v, err);
            end
        end else begin
            grown = {1'b0, ramp_q[j]} + {1'b0, step_change_q};
            ramp_q[j] = (grown < {1'b0, step_limit_q}) ? grown[STEP_W-1:0] : step_limit_q;
            step_v = longint'(ramp_q[j]);
            nxt = step_toward(prev_q[j], step_v, err);
        end
        prev_q[j] = longint'($signed(it.meas));
        res.joint = it.joint;
        res.pos = nxt[POS_W-1:0];
        return 1;
    endfunction

    function automatic joint_item_t next_item();
        joint_item_t it;
        int unsigned pick, j;
        longint span, pos;
        j = $urandom_range(0, JOINT_COUNT - 1);
        pick = $urandom_range(0, 99);
        it.cmd = CMD_TICK;
        it.joint = j[JOINT_W-1:0];
        it.meas = $urandom;
        it.tgt = $urandom;
        if (pick < 20) begin
            // unstructured noise, including the unused code and the out-of-range joint
            it.cmd = CMD_W'($urandom_range(0, 3));
            it.joint = JOINT_W'($urandom_range(0, 7));
            if (it.cmd == CMD_TICK && it.joint < JOINT_COUNT && !started[it.joint])
                it.cmd = CMD_START;
            return it;
        end
        if (!started[j] || pick < 24) begin
            it.cmd = CMD_START;
            if ($urandom_range(0, 3) != 0)
                it.meas = POS_W'(sat_pos(plant_q[j] + longint'($urandom_range(0, 2000))
                                         - 1000));
        end else if (pick < 34) begin
            it.cmd = CMD_TARGET;
            case ($urandom_range(0, 3))
                0: span = 2 * longint'(step_limit_q) + 1;
                1: span = 3 * longint'(ramp_dist_q) + 1;
                2: span = 64'sd1 << 20;
                default: span = -1;
            endcase
            if (span >= 0) begin
                pos = longint'($urandom_range(0, span[31:0]));
                it.tgt = POS_W'(sat_pos($urandom_range(0, 1) ? plant_q[j] + pos
                                                              : plant_q[j] - pos));
            end
        end else begin
            // closed loop: the joint follows its last command with a little noise
            if ($urandom_range(0, 19) == 0)
                pos = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
            else
                pos = longint'($urandom_range(0, 64)) - 32;
            if ($urandom_range(0, 49) != 0)
                it.meas = POS_W'(sat_pos(plant_q[j] + pos));
        end
        return it;
    endfunction

    task automatic plan_item(input logic [CMD_W-1:0] cmd, input int joint,
                             input logic [POS_W-1:0] meas, input logic [POS_W-1:0] tgt,
                             input bit typed, input logic [POS_W-1:0] pos);
        plan_row_t row;
        row = '0;
        row.item.cmd = cmd;
        row.item.joint = JOINT_W'(joint);
        row.item.meas = meas;
        row.item.tgt = tgt;
        row.typed = typed;
        row.typed_pos = pos;
        plan.push_back(row);
    endtask

    task automatic plan_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.cfg_row = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        plan.push_back(row);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_PROFILE_MODE:  mode_q = val[0];
            REG_STEP_LIMIT:    step_limit_q = val[STEP_W-1:0];
            REG_STEP_CHANGE:   step_change_q = val[STEP_W-1:0];
            REG_RAMP_DISTANCE: ramp_dist_q = val[DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic mode, input longint ms, input longint sc,
                                  input longint rd);
        write_reg(REG_PROFILE_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
        write_reg(REG_STEP_LIMIT, ms[CFG_DATA_W-1:0]);
        write_reg(REG_STEP_CHANGE, sc[CFG_DATA_W-1:0]);
        write_reg(REG_RAMP_DISTANCE, rd[CFG_DATA_W-1:0]);
    endtask

    task automatic send_item(input joint_item_t it, input bit typed,
                             input logic [POS_W-1:0] typed_pos);
        joint_cmd_t res;
        bit has_res;
        s_valid <= 1'b1;
        s_cmd <= it.cmd;
        s_joint_index <= it.joint;
        s_measured_position <= it.meas;
        s_target_position <= it.tgt;
        do @(posedge aclk); while (!s_ready);
        has_res = shape_command(it, res);
        if (it.joint < JOINT_COUNT) begin
            if (it.cmd == CMD_START) begin
                started[it.joint] = 1'b1;
                plant_q[it.joint] = longint'($signed(it.meas));
            end
            if (has_res) plant_q[it.joint] = longint'($signed(res.pos));
        end
        if (has_res) begin
            if (typed) res.pos = typed_pos;
            cmd_due.push_back(res);
        end
        sent_count++;
    endtask

    // random sender gaps, with occasional bursts where neither side stalls
    task automatic idle_gap();
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 49) == 0) calm_left = 16;
        calm = calm_left > 0;
        while (!calm && $urandom_range(0, 99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (cmd_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    always @(posedge aclk) m_ready <= calm || ($urandom_range(0, 99) >= rcv_idle_pct);

    always @(posedge aclk) begin : result_check
        joint_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cmd_due.size() == 0) begin
                $display("%t: unexpected command, expected none, got joint %0d position %0d",
                         $time, m_out_joint, m_command_position);
                fault_count++;
            end else begin
                want = cmd_due.pop_front();
                checked_count++;
                if (m_out_joint !== want.joint) begin
                    $display("%t: out_joint mismatch, expected %0d, got %0d",
                             $time, want.joint, m_out_joint);
                    fault_count++;
                end
                if (m_command_position !== want.pos) begin
                    $display("%t: command_position mismatch, expected %0d, got %0d",
                             $time, $signed(want.pos), m_command_position);
                    fault_count++;
                end
            end
        end
    end

    initial begin : stimulus
        joint_item_t it;
        int phase, counted;
        logic mode_v;
        longint ms, sc, rd;

        for (int j = 0; j < JOINT_COUNT; j++) begin
            goal_q[j] = 0;
            prev_q[j] = 0;
            ramp_q[j] = '0;
            started[j] = 1'b0;
            plant_q[j] = 0;
        end

        // reset settings: trapezoid, step 80531, change 8053, ramp distance 402653
        plan_item(CMD_START,  0, 32'd0, 32'd0, 0, 0);
        plan_item(CMD_TICK,   0, 32'd0, 32'd0, 1, 32'd0);              // zero error, no ramp
        plan_item(CMD_TARGET, 0, 32'd0, 32'd1_000_000, 0, 0);
        plan_item(CMD_TICK,   0, 32'd0, 32'd0, 1, 32'd8053);           // first ramp step
        plan_item(CMD_TICK,   0, 32'd8053, 32'd0, 0, 0);
        plan_item(CMD_START,  1, 32'h7FFF_FF00, 32'd0, 0, 0);
        plan_item(CMD_TARGET, 1, 32'd0, 32'h7FFF_FFFF, 0, 0);
        plan_item(CMD_TICK,   1, 32'h8000_0000, 32'd0, 1, 32'h7FFF_FFFF);  // positive clamp
        plan_item(CMD_START,  2, 32'h8000_0100, 32'd0, 0, 0);
        plan_item(CMD_TARGET, 2, 32'd0, 32'h8000_0000, 0, 0);
        plan_item(CMD_TICK,   2, 32'h7FFF_FFFF, 32'd0, 1, 32'h8000_0000);  // negative clamp
        plan_item(CMD_UNUSED, 0, 32'hDEAD_BEEF, 32'h1234_5678, 0, 0);      // ignored
        plan_item(CMD_TICK,   7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);      // joint out of range
        plan_item(CMD_TICK,   0, 32'd1_000_000, 32'd0, 1, 32'd0);    // zero error while ramping
        plan_reg(REG_PROFILE_MODE, {{(CFG_DATA_W-1){1'b0}}, profile_constant});
        plan_item(CMD_START,  3, 32'd100, 32'd0, 0, 0);
        plan_item(CMD_TICK,   3, 32'd100, 32'd0, 1, 32'd100);
        plan_item(CMD_TARGET, 3, 32'd0, 32'd80631, 0, 0);
        plan_item(CMD_TICK,   3, 32'd100, 32'd0, 1, 32'd80631);        // error exactly one step
        plan_item(CMD_TARGET, 3, 32'd0, 32'd1_000_000, 0, 0);
        plan_item(CMD_TICK,   3, 32'd100, 32'd0, 1, 32'd80631);
        plan_item(CMD_TARGET, 3, 32'd0, -32'sd1_000_000, 0, 0);
        plan_item(CMD_TICK,   3, 32'd0, 32'd0, 1, -32'sd80431);
        plan_reg(REG_STEP_LIMIT, STEP_FULL[CFG_DATA_W-1:0]);
        plan_item(CMD_START,  1, 32'h7FFF_FFF0, 32'd0, 0, 0);
        plan_item(CMD_TARGET, 1, 32'd0, 32'h7FFF_FFFF, 0, 0);
        plan_item(CMD_TICK,   1, 32'h8000_0000, 32'd0, 1, 32'h7FFF_FFFF);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].cfg_row) begin
                settle();
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            end else begin
                send_item(plan[i].item, plan[i].typed, plan[i].typed_pos);
                idle_gap();
            end
        end

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            snd_idle_pct = (phase < 3) ? 15 : (phase < 6) ? 82 : 0;
            rcv_idle_pct = (phase < 3) ? 82 : (phase < 6) ? 15 : 0;
            case (phase)
                0: begin mode_v = 1'b1; ms = longint'(RST_STEP_LIMIT);
                         sc = longint'(RST_STEP_CHANGE);
                         rd = longint'(RST_RAMP_DISTANCE); end
                1: begin mode_v = profile_constant; ms = longint'($urandom_range(1, 1 << 20));
                         sc = longint'($urandom_range(0, 1 << 16));
                         rd = longint'($urandom_range(0, 1 << 22)); end
                2: begin mode_v = 1'b1; ms = longint'($urandom_range(4096, 65535));
                         sc = longint'($urandom_range(64, 4096)); rd = ms * ms / (2 * sc); end
                3: begin mode_v = 1'b1; ms = 0; sc = longint'($urandom_range(1, 1 << 16));
                         rd = longint'($urandom_range(0, 1 << 22)); end
                4: begin mode_v = 1'b1; ms = STEP_FULL; sc = 0;
                         rd = longint'($urandom_range(0, 1 << 24)); end
                5: begin mode_v = 1'b1; ms = longint'($urandom_range(1, 1 << 18));
                         sc = longint'($urandom_range(1, 1 << 14)); rd = 0; end
                6: begin mode_v = 1'b1; ms = STEP_FULL; sc = STEP_FULL; rd = DIST_FULL; end
                default: begin mode_v = profile_constant; ms = STEP_FULL;
                         sc = longint'($urandom_range(0, STEP_FULL[31:0]));
                         rd = longint'($urandom_range(0, DIST_FULL[31:0])); end
            endcase
            apply_settings(mode_v, ms, sc, rd);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = next_item();
                send_item(it, 0, 0);
                counted++;
                idle_gap();
            end
        end

        settle();
        calm = 1'b0;
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d directed rows and %0d settings phases: %0d transactions in,",
                 plan.size(), PHASES, sent_count);
        $display("%0d commands compared, %0d mismatches", checked_count, fault_count);
        if (fault_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
